@@ design/nsb_pkg.sv @@
`default_nettype none

package nsb_pkg;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd2;

  localparam logic [10:0] OUT_WIDTH_RST  = 11'd240;
  localparam logic [10:0] OUT_HEIGHT_RST = 11'd320;
  localparam logic [8:0]  GAIN_ONE       = 9'd256;

endpackage

`default_nettype wire

@@ design/nearest_scale_brightness_rgb565.sv @@
// Path: input register, coordinate divider stages, address register, frame-store read and
//   output register; QD, the quotient width, is max(clog2(SRC_WIDTH+1), clog2(SRC_HEIGHT+1)).
// Throughput: one item per cycle unless the output stalls; the coordinate dividers retire one
//   quotient bit per stage and the frame store takes one read or one write per cycle.
// A waiting result stalls the pipe only when the next render reaches the output.
// Reset (rst, synchronous) clears valid bits, sets registers to 240, 320, 256; store undefined.
`default_nettype none

module nearest_scale_brightness_rgb565 import nsb_pkg::*; #(
  parameter int SRC_WIDTH  = 240,
  parameter int SRC_HEIGHT = 320
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  mode,
  input  wire logic [16:0]           load_index,
  input  wire logic [15:0]           load_pixel,
  input  wire logic [9:0]            out_x,
  input  wire logic [9:0]            out_y,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [15:0]                pixel_out,
  output logic                       coord_error
);

  localparam int QX    = $clog2(SRC_WIDTH + 1);
  localparam int QY    = $clog2(SRC_HEIGHT + 1);
  localparam int QD    = (QX > QY) ? QX : QY;
  localparam int NW    = 10 + QD;
  localparam int DEPTH = SRC_WIDTH * SRC_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    logic          render;
    logic          err;
    logic          ld_ok;
    logic [AW-1:0] ld_addr;
    logic [15:0]   pixel;
    logic [NW-1:0] rem_x;
    logic [NW-1:0] rem_y;
    logic [QD-1:0] qx;
    logic [QD-1:0] qy;
  } div_item_t;

  logic [10:0] out_width;
  logic [10:0] out_height;
  logic [8:0]  brightness;

  logic        en;
  div_item_t   div_pipe [QD+1];
  logic [QD:0] div_vld;

  logic          a_vld;
  logic          a_render;
  logic          a_err;
  logic          a_we;
  logic [AW-1:0] a_addr;
  logic [15:0]   a_pixel;

  logic [15:0] frame_store [DEPTH];
  logic [15:0] rd_data;
  logic        d_vld;
  logic        d_render;
  logic        d_err;

  logic [8:0]  gain;
  logic [13:0] r_prod;
  logic [14:0] g_prod;
  logic [13:0] b_prod;

  assign en       = !(d_vld && d_render && out_valid && !out_ready);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_width  <= OUT_WIDTH_RST;
      out_height <= OUT_HEIGHT_RST;
      brightness <= GAIN_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OUT_WIDTH:  out_width  <= cfg_data[10:0];
        CFG_OUT_HEIGHT: out_height <= cfg_data[10:0];
        CFG_BRIGHTNESS: brightness <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld <= '0;
      a_vld   <= 1'b0;
      d_vld   <= 1'b0;
    end else if (en) begin
      div_vld <= {div_vld[QD-1:0], in_valid};
      a_vld   <= div_vld[QD];
      d_vld   <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_pipe[0].render  <= (mode == MODE_RENDER);
      div_pipe[0].err     <= ({1'b0, out_x} >= out_width) || ({1'b0, out_y} >= out_height);
      div_pipe[0].ld_ok   <= (32'(load_index) < 32'(DEPTH));
      div_pipe[0].ld_addr <= AW'(load_index);
      div_pipe[0].pixel   <= load_pixel;
      div_pipe[0].rem_x   <= NW'(32'(out_x) * SRC_WIDTH);
      div_pipe[0].rem_y   <= NW'(32'(out_y) * SRC_HEIGHT);
      div_pipe[0].qx      <= '0;
      div_pipe[0].qy      <= '0;
    end
  end

  for (genvar k = 1; k <= QD; k++) begin : g_div
    localparam int BIT = QD - k;
    logic [NW-1:0] dx;
    logic [NW-1:0] dy;
    div_item_t     nxt;

    always_comb begin
      dx  = NW'(out_width) << BIT;
      dy  = NW'(out_height) << BIT;
      nxt = div_pipe[k-1];
      if (div_pipe[k-1].rem_x >= dx) begin
        nxt.rem_x   = div_pipe[k-1].rem_x - dx;
        nxt.qx[BIT] = 1'b1;
      end
      if (div_pipe[k-1].rem_y >= dy) begin
        nxt.rem_y   = div_pipe[k-1].rem_y - dy;
        nxt.qy[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_pipe[k] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_render <= div_pipe[QD].render;
      a_err    <= div_pipe[QD].err;
      a_we     <= !div_pipe[QD].render && div_pipe[QD].ld_ok;
      a_pixel  <= div_pipe[QD].pixel;
      if (div_pipe[QD].render) begin
        a_addr <= AW'(32'(div_pipe[QD].qy) * SRC_WIDTH + 32'(div_pipe[QD].qx));
      end else begin
        a_addr <= div_pipe[QD].ld_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && a_vld) begin
      if (a_we) begin
        frame_store[a_addr] <= a_pixel;
      end
      if (a_render && !a_err) begin
        rd_data <= frame_store[a_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_render <= a_render;
      d_err    <= a_err;
    end
  end

  always_comb begin
    gain   = (brightness > GAIN_ONE) ? GAIN_ONE : brightness;
    r_prod = 14'(rd_data[15:11]) * 14'(gain);
    g_prod = 15'(rd_data[10:5]) * 15'(gain);
    b_prod = 14'(rd_data[4:0]) * 14'(gain);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && d_vld && d_render) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && d_vld && d_render) begin
      coord_error <= d_err;
      if (d_err) begin
        pixel_out <= '0;
      end else begin
        pixel_out <= {r_prod[12:8], g_prod[13:8], b_prod[12:8]};
      end
    end
  end

endmodule

`default_nettype wire

@@ design/nsb_checker.sv @@
`default_nettype none

module nsb_checker import nsb_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] pixel_out,
  input wire logic        coord_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(coord_error))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && coord_error |-> pixel_out == 16'd0)
    else $error("coordinate error with nonzero pixel");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind nearest_scale_brightness_rgb565 nsb_checker u_nsb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .pixel_out   (pixel_out),
  .coord_error (coord_error)
);

`default_nettype wire
